### rtl/tmf_pkg.sv
// Shared constants and types for the trimmed mean filter.
package tmf_pkg;

    localparam int SAMPLE_W    = 13;
    localparam int MEAN_W      = 17;
    localparam int COUNT_W     = 5;
    localparam int MIN_BATCH   = 5;
    localparam int TRIM        = 2;
    localparam int FRAC_BITS   = 4;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd7;

    // Per-cycle command to every cell of the sorted chain.
    typedef struct packed {
        logic insert;   // place the incoming sample in order
        logic drain;    // move every value one cell toward cell 0
    } cell_ctl_t;

endpackage

### rtl/tmf_cell.sv
// One cell of the insertion chain: holds one sorted sample.
module tmf_cell
(
    input  logic                         clk,
    input  tmf_pkg::cell_ctl_t           ctl,
    input  logic [tmf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                         occ,
    input  logic                         prev_occ,
    input  logic                         prev_shift,
    input  logic [tmf_pkg::SAMPLE_W-1:0] prev_val,
    input  logic [tmf_pkg::SAMPLE_W-1:0] next_val,
    output logic                         shift,
    output logic [tmf_pkg::SAMPLE_W-1:0] val
);

    logic [tmf_pkg::SAMPLE_W-1:0] val_reg;

    // Strict compare: a new sample lands after held samples of equal value.
    assign shift = occ && (sample_in < val_reg);
    assign val   = val_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.insert)
        begin
            if (prev_shift)
                val_reg <= prev_val;
            else if (shift || (!occ && prev_occ))
                val_reg <= sample_in;
        end
        else if (ctl.drain)
        begin
            val_reg <= next_val;
        end
    end

endmodule

### rtl/tmf_divider.sv
// Restoring divider, one quotient bit per cycle.
module tmf_divider
#(
    parameter int DVD_W = 21,
    parameter int DVS_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W+1:0] rem_sh;
    logic [DVS_W+1:0] rem_diff;
    logic             take;

    assign rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {2'b00, dvs_reg};
    assign take     = rem_sh >= {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], take};
            // remainder stays below the divisor, so it fits DVS_W+1 bits
            rem_reg <= take ? rem_diff[DVS_W:0] : rem_sh[DVS_W:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/trimmed_mean_filter_unit.sv
// Top level: sorted insertion chain, drain accumulator and mean divider.
//
//  channel  | ports                            | handshake
//  ---------+----------------------------------+--------------------------------
//  input    | start, busy, sample[12:0]        | taken when start && !busy
//  result   | mean_valid, mean_q4[16:0]        | one-cycle strobe, no backpressure
//  config   | sample_count_we, sample_count    | written when sample_count_we
//
// A sample that does not close a batch leaves the unit idle; the next may follow at once.
// A closing sample raises busy while the chain of m samples (m = batch size) drains
// through the accumulator, and then while the bit-serial divider runs.
// mean_valid pulses for one cycle, in the same cycle that busy falls.
// Reset empties the batch and sets sample_count to 7; the store itself is not cleared.
module trimmed_mean_filter_unit
#(
    parameter int MAX_SAMPLES = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tmf_pkg::SAMPLE_W-1:0] sample,
    input  logic                         sample_count_we,
    input  logic [tmf_pkg::COUNT_W-1:0]  sample_count,
    output logic                         mean_valid,
    output logic [tmf_pkg::MEAN_W-1:0]   mean_q4
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int DVS_W = $clog2(MAX_SAMPLES - 3);
    localparam int SUM_W = tmf_pkg::SAMPLE_W + DVS_W;
    localparam int DVD_W = SUM_W + tmf_pkg::FRAC_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_DRAIN, ST_DIVIDE} state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             fill_count_reg;
    logic [tmf_pkg::COUNT_W-1:0]  sample_count_reg;
    logic [CNT_W-1:0]             m_reg;
    logic [IDX_W-1:0]             k_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic                         mean_valid_reg;
    logic [tmf_pkg::MEAN_W-1:0]   mean_q4_reg;
    logic                         div_start_reg;

    logic                         accept;
    logic [CNT_W:0]               fill_plus;
    logic [CNT_W-1:0]             batch;
    logic                         closing;
    tmf_pkg::cell_ctl_t           ctl;
    logic [MAX_SAMPLES-1:0]       occ;
    logic [MAX_SAMPLES-1:0]       shift;
    logic [tmf_pkg::SAMPLE_W-1:0] val [MAX_SAMPLES];
    logic                         keep;
    logic                         div_done;
    logic [DVD_W-1:0]             div_q;

    assign accept    = start && (state_reg == ST_IDLE);
    assign fill_plus = {1'b0, fill_count_reg} + 1'b1;

    always_comb
    begin
        if (32'(sample_count_reg) < tmf_pkg::MIN_BATCH)
            batch = CNT_W'(tmf_pkg::MIN_BATCH);
        else if (32'(sample_count_reg) > MAX_SAMPLES)
            batch = CNT_W'(MAX_SAMPLES);
        else
            batch = CNT_W'(sample_count_reg);
    end

    assign closing    = fill_plus >= {1'b0, batch};
    assign ctl.insert = accept && (32'(fill_count_reg) < MAX_SAMPLES);
    assign ctl.drain  = (state_reg == ST_DRAIN);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SAMPLES; gi++)
        begin : g_cell
            assign occ[gi] = 32'(fill_count_reg) > gi;
            if (gi == 0)
            begin : g_first
                tmf_cell u_cell
                (
                    .clk        (clk),
                    .ctl        (ctl),
                    .sample_in  (sample),
                    .occ        (occ[0]),
                    .prev_occ   (1'b1),
                    .prev_shift (1'b0),
                    .prev_val   ('0),
                    .next_val   (val[(MAX_SAMPLES > 1) ? 1 : 0]),
                    .shift      (shift[0]),
                    .val        (val[0])
                );
            end
            else if (gi == MAX_SAMPLES - 1)
            begin : g_last
                tmf_cell u_cell
                (
                    .clk        (clk),
                    .ctl        (ctl),
                    .sample_in  (sample),
                    .occ        (occ[gi]),
                    .prev_occ   (occ[gi-1]),
                    .prev_shift (shift[gi-1]),
                    .prev_val   (val[gi-1]),
                    .next_val   ('0),
                    .shift      (shift[gi]),
                    .val        (val[gi])
                );
            end
            else
            begin : g_mid
                tmf_cell u_cell
                (
                    .clk        (clk),
                    .ctl        (ctl),
                    .sample_in  (sample),
                    .occ        (occ[gi]),
                    .prev_occ   (occ[gi-1]),
                    .prev_shift (shift[gi-1]),
                    .prev_val   (val[gi-1]),
                    .next_val   (val[gi+1]),
                    .shift      (shift[gi]),
                    .val        (val[gi])
                );
            end
        end
    endgenerate

    // Sorted position k sits in cell 0 while k_reg is k; keep the untrimmed middle.
    assign keep = (32'(k_reg) >= tmf_pkg::TRIM) &&
                  ((32'(k_reg) + tmf_pkg::TRIM) < 32'(m_reg));

    tmf_divider
    #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend ({sum_reg, {tmf_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (DVS_W'(m_reg - CNT_W'(2 * tmf_pkg::TRIM))),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_count_reg   <= '0;
            sample_count_reg <= tmf_pkg::COUNT_RESET;
            m_reg            <= CNT_W'(tmf_pkg::MIN_BATCH);
            k_reg            <= '0;
            mean_valid_reg   <= 1'b0;
            div_start_reg    <= 1'b0;
        end
        else
        begin
            mean_valid_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            if (sample_count_we)
                sample_count_reg <= sample_count;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (closing)
                        begin
                            m_reg          <= fill_plus[CNT_W-1:0];
                            fill_count_reg <= '0;
                            k_reg          <= '0;
                            state_reg      <= ST_DRAIN;
                        end
                        else
                        begin
                            fill_count_reg <= fill_plus[CNT_W-1:0];
                        end
                    end
                end
                ST_DRAIN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == IDX_W'(m_reg - 1'b1))
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        mean_valid_reg <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sum_reg <= '0;
        else if (state_reg == ST_DRAIN && keep)
            sum_reg <= sum_reg + SUM_W'(val[0]);
        if (div_done)
            mean_q4_reg <= div_q[tmf_pkg::MEAN_W-1:0];
    end

    assign busy       = (state_reg != ST_IDLE);
    assign mean_valid = mean_valid_reg;
    assign mean_q4    = mean_q4_reg;

    a_fill_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_count_reg) < MAX_SAMPLES)
        else $error("fill count reached store size");

    a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (fill_count_reg == '0))
        else $error("batch not emptied while computing mean");

    a_batch_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ((32'(m_reg) >= tmf_pkg::MIN_BATCH) && (32'(m_reg) <= MAX_SAMPLES)))
        else $error("closed batch size out of range");

    a_result_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
        mean_valid |-> $past(state_reg == ST_DIVIDE))
        else $error("result strobe without a division");

endmodule
